// ===== rtl/core/phm_pkg.sv =====
// Package for the peak-hold level meter: constants, payload and control types,
// and the step, factor and divider tables. No dependencies.
package phm_pkg;

  localparam int BANDS       = 128;
  localparam int ADDR_W      = $clog2(BANDS);
  localparam int BAND_W      = 7;
  localparam int RAW_W       = 8;
  localparam int LVL_W       = 16;
  localparam int SPD_W       = 24;
  localparam int FAC_W       = 17;
  localparam int SEL_W       = 3;
  localparam int CNT_W       = 3;
  localparam int CFG_DATA_W  = 3;
  localparam int VOICE_BANDS = 16;
  localparam int VOICE_W     = $clog2(VOICE_BANDS);
  localparam int PS_W        = LVL_W + SPD_W;

  localparam logic [SPD_W-1:0]   SPEED_START = SPD_W'(655);
  localparam logic [LVL_W-1:0]   SCOPE_CLEAR = LVL_W'(16'h0600);
  localparam logic [VOICE_W-1:0] VOICE_LAST  = VOICE_W'(VOICE_BANDS - 1);

  typedef enum logic [1:0] {
    MODE_ANALYZER = 2'd0,
    MODE_VOICE    = 2'd1,
    MODE_SCOPE    = 2'd2,
    MODE_PLAIN    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_DISPLAY_MODE = 2'd0,
    REG_LEVEL_FALL   = 2'd1,
    REG_PEAK_ACCEL   = 2'd2,
    REG_REDRAW       = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [BAND_W-1:0] band;
    logic [RAW_W-1:0]  level_in;
    logic              has_level;
    logic              falloff_tick;
    logic              frame_end;
    logic              clear_band;
  } phm_in_t;

  typedef struct packed {
    logic [LVL_W-1:0] level_out;
    logic [LVL_W-1:0] peak_out;
    logic             redraw;
  } phm_out_t;

  typedef struct packed {
    cfg_reg_e                reg_index;
    logic [CFG_DATA_W-1:0]   wdata;
  } phm_cfg_t;

  typedef struct packed {
    mode_e            mode;
    logic [SEL_W-1:0] fall_sel;
    logic [SEL_W-1:0] accel_sel;
  } phm_conf_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [LVL_W-1:0] peak;
    logic [SPD_W-1:0] speed;
  } phm_state_t;

  typedef struct packed {
    logic              lvl_en;
    logic [ADDR_W-1:0] lvl_addr;
    logic [LVL_W-1:0]  lvl_data;
    logic              ps_en;
    logic [LVL_W-1:0]  peak;
    logic [SPD_W-1:0]  speed;
    logic [LVL_W-1:0]  res_level;
    logic [LVL_W-1:0]  res_peak;
  } phm_upd_t;

  function automatic logic [LVL_W-1:0] fall_step(input logic [SEL_W-1:0] sel);
    logic [LVL_W-1:0] r;
    unique case (sel)
      3'd0:    r = LVL_W'(87);
      3'd1:    r = LVL_W'(128);
      3'd2:    r = LVL_W'(256);
      3'd3:    r = LVL_W'(333);
      default: r = LVL_W'(410);
    endcase
    return r;
  endfunction

  function automatic logic [FAC_W-1:0] accel_factor(input logic [SEL_W-1:0] sel);
    logic [FAC_W-1:0] r;
    unique case (sel)
      3'd0:    r = FAC_W'(78643);
      3'd1:    r = FAC_W'(85197);
      3'd2:    r = FAC_W'(91750);
      3'd3:    r = FAC_W'(98304);
      default: r = FAC_W'(104858);
    endcase
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] divider_m1(input logic [1:0] sel);
    logic [CNT_W-1:0] r;
    unique case (sel)
      2'd0: r = CNT_W'(0);
      2'd1: r = CNT_W'(1);
      2'd2: r = CNT_W'(3);
      2'd3: r = CNT_W'(7);
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/phm_if.sv =====
// Valid/ready channel interfaces for the level meter: item, result and config.
// Depends on phm_pkg for the payload types.
interface phm_in_if;
  logic              valid;
  logic              ready;
  phm_pkg::phm_in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface phm_out_if;
  logic              valid;
  logic              ready;
  phm_pkg::phm_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface phm_cfg_if;
  logic              valid;
  logic              ready;
  phm_pkg::phm_cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/phm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module phm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/phm_update.sv =====
// Per-band update datapath: analyzer rise/fall, peak fall with speed growth,
// copy modes and clear. Depends on phm_pkg.
module phm_update (
  input  phm_pkg::phm_in_t    item_i,
  input  phm_pkg::phm_conf_t  conf_i,
  input  phm_pkg::phm_state_t cur_i,
  output phm_pkg::phm_upd_t   upd_o
);

  localparam int PROD_W = phm_pkg::SPD_W + phm_pkg::FAC_W;

  logic                          in_range;
  logic [phm_pkg::ADDR_W-1:0]    addr;
  logic [phm_pkg::ADDR_W-1:0]    vaddr;
  logic [phm_pkg::LVL_W-1:0]     lvl;
  logic [phm_pkg::LVL_W-1:0]     step;
  logic [phm_pkg::LVL_W-1:0]     dec;
  logic [phm_pkg::LVL_W-1:0]     drop;
  logic [phm_pkg::LVL_W-1:0]     pk_sub;
  logic [PROD_W-1:0]             prod;
  logic [phm_pkg::SPD_W:0]       sp;
  logic [phm_pkg::SPD_W-1:0]     sp_sat;
  logic                          rise;
  logic                          take_peak;
  logic                          do_fall;
  logic [phm_pkg::LVL_W-1:0]     nl;
  logic [phm_pkg::LVL_W-1:0]     np;
  logic [phm_pkg::SPD_W-1:0]     ns;
  logic [phm_pkg::LVL_W-1:0]     pk_fall;

  assign in_range = 32'(item_i.band) < 32'(phm_pkg::BANDS);
  assign addr     = phm_pkg::ADDR_W'(item_i.band);
  assign vaddr    = phm_pkg::ADDR_W'(phm_pkg::VOICE_LAST -
                                     item_i.band[phm_pkg::VOICE_W-1:0]);
  assign lvl      = {item_i.level_in, 8'h00};
  assign step     = phm_pkg::fall_step(conf_i.fall_sel);
  assign dec      = (step >= cur_i.level) ? '0 : cur_i.level - step;

  assign drop     = cur_i.speed[phm_pkg::SPD_W-1:8];
  assign pk_sub   = (drop >= cur_i.peak) ? '0 : cur_i.peak - drop;
  assign prod     = PROD_W'(cur_i.speed) * PROD_W'(phm_pkg::accel_factor(conf_i.accel_sel));
  assign sp       = prod[PROD_W-1 -: (phm_pkg::SPD_W + 1)];
  assign sp_sat   = sp[phm_pkg::SPD_W] ? '1 : sp[phm_pkg::SPD_W-1:0];

  assign rise      = item_i.has_level && (lvl > cur_i.level);
  assign take_peak = rise && (lvl > cur_i.peak);
  assign nl        = rise ? lvl : (item_i.falloff_tick ? dec : cur_i.level);
  assign do_fall   = (rise || item_i.falloff_tick) && !take_peak && (cur_i.peak != '0);
  assign pk_fall   = (pk_sub < nl) ? nl : pk_sub;

  always_comb begin
    np = cur_i.peak;
    ns = cur_i.speed;
    if (take_peak) begin
      np = lvl;
      ns = phm_pkg::SPEED_START;
    end else if (do_fall) begin
      np = pk_fall;
      ns = sp_sat;
    end
  end

  always_comb begin
    upd_o          = '0;
    upd_o.lvl_addr = addr;
    upd_o.lvl_data = cur_i.level;
    upd_o.peak     = cur_i.peak;
    upd_o.speed    = cur_i.speed;
    if (in_range) begin
      if (item_i.clear_band) begin
        upd_o.lvl_en   = 1'b1;
        upd_o.lvl_data = (conf_i.mode == phm_pkg::MODE_SCOPE) ? phm_pkg::SCOPE_CLEAR : '0;
        upd_o.ps_en    = 1'b1;
        upd_o.peak     = '0;
      end else begin
        unique case (conf_i.mode)
          phm_pkg::MODE_ANALYZER: begin
            upd_o.lvl_en   = 1'b1;
            upd_o.lvl_data = nl;
            upd_o.ps_en    = 1'b1;
            upd_o.peak     = np;
            upd_o.speed    = ns;
          end
          phm_pkg::MODE_VOICE: begin
            if (item_i.has_level && (32'(item_i.band) < 32'(phm_pkg::VOICE_BANDS))) begin
              upd_o.lvl_en   = 1'b1;
              upd_o.lvl_addr = vaddr;
              upd_o.lvl_data = lvl;
            end
          end
          phm_pkg::MODE_SCOPE, phm_pkg::MODE_PLAIN: begin
            if (item_i.has_level) begin
              upd_o.lvl_en   = 1'b1;
              upd_o.lvl_data = lvl;
            end
          end
        endcase
      end
      upd_o.res_level = (upd_o.lvl_en && (upd_o.lvl_addr == addr)) ? upd_o.lvl_data
                                                                   : cur_i.level;
      upd_o.res_peak  = upd_o.ps_en ? upd_o.peak : cur_i.peak;
    end
  end

endmodule

// ===== rtl/core/peak_hold_level_meter_top.sv =====
// Top level of the peak-hold level meter: config registers, store RAMs with
// valid bits and write forwarding, redraw divider, output register.
// Depends on phm_pkg, phm_if, phm_ram and phm_update.
//
// Usage: item_i carries one band transaction (band, level byte, has_level,
// falloff_tick, frame_end, clear_band); res_o returns exactly one result per
// item (level_out, peak_out in unsigned 8.8, redraw), in order. cfg_i writes
// register reg_index with wdata; it is always ready. The user must write it
// only while the block is idle; the block itself does not enforce this.
// Pipeline: the accepted item is registered in the update stage, and its result
// in the output register that drives res_o.valid. The block takes one item per
// cycle while res_o is not held: the item is read from the level RAM and the
// peak/speed RAM when it is accepted, then updated and written back from the
// update stage, with the last write forwarded to the following item.
// Reset: all bands read as zero through per-entry valid bits, so no clearing
// pass is needed; registers take display_mode 0, level_fall_select 2,
// peak_accel_select 0, redraw_select 0, redraw count 0.
// Stall: while res_o is held, the update stage holds, and item_i.ready drops
// once that stage is full; results are neither lost nor repeated.
module peak_hold_level_meter_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  phm_in_if.sink    item_i,
  phm_out_if.source res_o,
  phm_cfg_if.sink   cfg_i
);

  localparam int AW = phm_pkg::ADDR_W;

  phm_pkg::phm_conf_t        conf_q;
  logic [1:0]                redraw_sel_q;
  logic [phm_pkg::CNT_W-1:0] redraw_cnt_q, redraw_cnt_d;

  logic                      acc;
  logic                      s1_valid_q;
  logic                      s1_adv;
  logic                      s1_fire;
  phm_pkg::phm_in_t          s1_item_q;
  logic [AW-1:0]             rd_addr;
  logic [AW-1:0]             s1_addr;
  logic                      lvld_q, psvld_q;
  logic [phm_pkg::BANDS-1:0] lvalid_q, psvalid_q;

  logic [phm_pkg::LVL_W-1:0] lrd;
  logic [phm_pkg::PS_W-1:0]  psrd;
  logic                      lfwd_en_q, psfwd_en_q;
  logic [AW-1:0]             lfwd_addr_q, psfwd_addr_q;
  logic [phm_pkg::LVL_W-1:0] lfwd_data_q;
  logic [phm_pkg::PS_W-1:0]  psfwd_data_q;
  logic [phm_pkg::PS_W-1:0]  ps_cur;
  logic                      lvl_we, ps_we;
  logic                      redraw;

  phm_pkg::phm_state_t       cur;
  phm_pkg::phm_upd_t         upd;

  logic                      out_valid_q;
  phm_pkg::phm_out_t         out_data_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conf_q.mode      <= phm_pkg::MODE_ANALYZER;
      conf_q.fall_sel  <= phm_pkg::SEL_W'(2);
      conf_q.accel_sel <= '0;
      redraw_sel_q     <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.reg_index)
        phm_pkg::REG_DISPLAY_MODE: conf_q.mode      <= phm_pkg::mode_e'(cfg_i.data.wdata[1:0]);
        phm_pkg::REG_LEVEL_FALL:   conf_q.fall_sel  <= cfg_i.data.wdata;
        phm_pkg::REG_PEAK_ACCEL:   conf_q.accel_sel <= cfg_i.data.wdata;
        phm_pkg::REG_REDRAW:       redraw_sel_q     <= cfg_i.data.wdata[1:0];
      endcase
    end
  end

  assign s1_adv       = !out_valid_q || res_o.ready;
  assign s1_fire      = s1_valid_q && s1_adv;
  assign item_i.ready = !s1_valid_q || s1_adv;
  assign acc          = item_i.valid && item_i.ready;
  assign rd_addr      = AW'(item_i.data.band);
  assign s1_addr      = AW'(s1_item_q.band);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      s1_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_item_q <= item_i.data;
      lvld_q    <= lvalid_q[rd_addr];
      psvld_q   <= psvalid_q[rd_addr];
    end
  end

  phm_ram #(.WIDTH(phm_pkg::LVL_W), .DEPTH(phm_pkg::BANDS)) u_level_ram (
    .clk_i   (clk_i),
    .we_i    (lvl_we),
    .waddr_i (upd.lvl_addr),
    .wdata_i (upd.lvl_data),
    .re_i    (acc),
    .raddr_i (rd_addr),
    .rdata_o (lrd)
  );

  phm_ram #(.WIDTH(phm_pkg::PS_W), .DEPTH(phm_pkg::BANDS)) u_peak_ram (
    .clk_i   (clk_i),
    .we_i    (ps_we),
    .waddr_i (s1_addr),
    .wdata_i ({upd.peak, upd.speed}),
    .re_i    (acc),
    .raddr_i (rd_addr),
    .rdata_o (psrd)
  );

  assign cur.level = (lfwd_en_q && (lfwd_addr_q == s1_addr)) ? lfwd_data_q
                   : (lvld_q ? lrd : '0);
  assign ps_cur    = (psfwd_en_q && (psfwd_addr_q == s1_addr)) ? psfwd_data_q
                   : (psvld_q ? psrd : '0);
  assign cur.peak  = ps_cur[phm_pkg::PS_W-1 -: phm_pkg::LVL_W];
  assign cur.speed = ps_cur[phm_pkg::SPD_W-1:0];

  phm_update u_update (
    .item_i (s1_item_q),
    .conf_i (conf_q),
    .cur_i  (cur),
    .upd_o  (upd)
  );

  assign lvl_we = s1_fire && upd.lvl_en;
  assign ps_we  = s1_fire && upd.ps_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfwd_en_q  <= 1'b0;
      psfwd_en_q <= 1'b0;
      lvalid_q   <= '0;
      psvalid_q  <= '0;
    end else begin
      if (lvl_we) begin
        lfwd_en_q              <= 1'b1;
        lvalid_q[upd.lvl_addr] <= 1'b1;
      end
      if (ps_we) begin
        psfwd_en_q         <= 1'b1;
        psvalid_q[s1_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (lvl_we) begin
      lfwd_addr_q <= upd.lvl_addr;
      lfwd_data_q <= upd.lvl_data;
    end
    if (ps_we) begin
      psfwd_addr_q <= s1_addr;
      psfwd_data_q <= {upd.peak, upd.speed};
    end
  end

  always_comb begin
    redraw       = 1'b0;
    redraw_cnt_d = redraw_cnt_q;
    if (s1_fire && s1_item_q.frame_end && s1_item_q.falloff_tick) begin
      if (redraw_cnt_q == '0) begin
        redraw       = 1'b1;
        redraw_cnt_d = phm_pkg::divider_m1(redraw_sel_q);
      end else begin
        redraw_cnt_d = redraw_cnt_q - phm_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      redraw_cnt_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      redraw_cnt_q <= redraw_cnt_d;
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_data_q.level_out <= upd.res_level;
      out_data_q.peak_out  <= upd.res_peak;
      out_data_q.redraw    <= redraw;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_data_q;

`ifndef SYNTHESIS
  a_write_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lvl_we || ps_we) |-> (s1_valid_q && s1_adv))
    else $error("store write without an advancing transaction");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !res_o.ready && out_valid_q) |-> !acc)
    else $error("transaction accepted while update stage is stalled");

  a_redraw_cnt_moves_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(redraw_cnt_q) |-> $past(s1_fire && s1_item_q.frame_end))
    else $error("redraw count changed without a frame-end transaction");

  a_result_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result appeared without an item in the update stage");

  a_voice_keeps_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ps_we |-> ((conf_q.mode == phm_pkg::MODE_ANALYZER) || s1_item_q.clear_band))
    else $error("peak store written outside analyzer mode without clear");
`endif

endmodule

// ===== dv/tb_peak_hold_level_meter_top.sv =====
// Testbench for peak_hold_level_meter_top: directed and random band traffic with a
// self-contained prediction of per-band level, peak and fall speed, and of the
// redraw divider. Depends on phm_pkg, phm_if and the RTL of the block.
module tb_peak_hold_level_meter_top;

  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 95;

  localparam logic [15:0] DECAY_STEP [5] = '{16'd87, 16'd128, 16'd256, 16'd333, 16'd410};
  localparam logic [16:0] SPEED_GAIN [5] = '{17'd78643, 17'd85197, 17'd91750, 17'd98304,
                                             17'd104858};
  localparam logic [2:0]  DIV_LOAD   [4] = '{3'd0, 3'd1, 3'd3, 3'd7};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  phm_in_if  item_if ();
  phm_out_if res_if ();
  phm_cfg_if cfg_if ();

  peak_hold_level_meter_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  logic [15:0]     lvl_mem [phm_pkg::BANDS];
  logic [15:0]     pk_mem  [phm_pkg::BANDS];
  logic [23:0]     spd_mem [phm_pkg::BANDS];
  logic [2:0]      frame_cnt;
  phm_pkg::mode_e  cur_mode;
  logic [2:0]      fall_sel;
  logic [2:0]      accel_sel;
  logic [1:0]      div_sel;

  phm_pkg::phm_out_t reading_q [$];
  int       err_cnt = 0;
  int       idle_cycles = 0;
  bit       gap_on = 1'b1;
  logic     stall_on = 1'b1;
  logic     hold_req = 1'b0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int sat_sel(input logic [2:0] s);
    return (s > 3'd4) ? 4 : int'(s);
  endfunction

  function automatic void peak_drop(input logic [6:0] b);
    logic [15:0] drop;
    logic [15:0] pk;
    logic [40:0] prod;
    drop = 16'(spd_mem[b] >> 8);
    pk   = (drop >= pk_mem[b]) ? 16'd0 : pk_mem[b] - drop;
    prod = (41'(spd_mem[b]) * 41'(SPEED_GAIN[sat_sel(accel_sel)])) >> 16;
    spd_mem[b] = (prod > 41'hFFFFFF) ? 24'hFFFFFF : prod[23:0];
    if (pk < lvl_mem[b]) pk = lvl_mem[b];
    pk_mem[b] = pk;
  endfunction

  function automatic phm_pkg::phm_out_t meter_update(input phm_pkg::phm_in_t it);
    logic [6:0]        b;
    logic [15:0]       lvl;
    logic [15:0]       step;
    phm_pkg::phm_out_t r;
    b   = it.band;
    lvl = {it.level_in, 8'h00};
    r   = '0;
    if (it.clear_band) begin
      lvl_mem[b] = (cur_mode == phm_pkg::MODE_SCOPE) ? phm_pkg::SCOPE_CLEAR : 16'd0;
      pk_mem[b]  = 16'd0;
    end else begin
      unique case (cur_mode)
        phm_pkg::MODE_ANALYZER: begin
          if (it.has_level && lvl > lvl_mem[b]) begin
            lvl_mem[b] = lvl;
            if (lvl > pk_mem[b]) begin
              pk_mem[b]  = lvl;
              spd_mem[b] = phm_pkg::SPEED_START;
            end else if (pk_mem[b] != 16'd0) begin
              peak_drop(b);
            end
          end else if (it.falloff_tick) begin
            step = DECAY_STEP[sat_sel(fall_sel)];
            if (lvl_mem[b] != 16'd0)
              lvl_mem[b] = (step >= lvl_mem[b]) ? 16'd0 : lvl_mem[b] - step;
            if (pk_mem[b] != 16'd0) peak_drop(b);
          end
        end
        phm_pkg::MODE_VOICE: begin
          if (it.has_level && b < 7'd16) lvl_mem[7'd15 - b] = lvl;
        end
        default: begin
          if (it.has_level) lvl_mem[b] = lvl;
        end
      endcase
    end
    if (it.frame_end && it.falloff_tick) begin
      if (frame_cnt == 3'd0) begin
        r.redraw  = 1'b1;
        frame_cnt = DIV_LOAD[div_sel];
      end else begin
        frame_cnt = frame_cnt - 3'd1;
      end
    end
    r.level_out = lvl_mem[b];
    r.peak_out  = pk_mem[b];
    return r;
  endfunction

  function automatic phm_pkg::phm_in_t mk_item(input logic [6:0] band,
                                               input logic [7:0] level,
                                               input logic has, input logic tick,
                                               input logic fend, input logic clr);
    phm_pkg::phm_in_t it;
    it.band         = band;
    it.level_in     = level;
    it.has_level    = has;
    it.falloff_tick = tick;
    it.frame_end    = fend;
    it.clear_band   = clr;
    return it;
  endfunction

  function automatic logic [7:0] rand_level();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 8'hFF;
    if (pick == 1) return 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic phm_pkg::phm_in_t rand_item();
    return mk_item(7'($urandom_range(0, 127)), rand_level(), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 15) == 0));
  endfunction

  task automatic send_item(input phm_pkg::phm_in_t it);
    int gap;
    gap = 0;
    if (gap_on && $urandom_range(0, 2) == 0)
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid <= 1'b1;
    item_if.data  <= it;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    reading_q.push_back(meter_update(it));
  endtask

  task automatic wait_idle();
    item_if.valid <= 1'b0;
    while (reading_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_config(input logic [2:0] m, input logic [2:0] fs,
                             input logic [2:0] as, input logic [2:0] ds);
    phm_pkg::cfg_reg_e idx;
    logic [2:0]        v;
    wait_idle();
    cfg_if.valid <= 1'b1;
    for (int k = 0; k < 4; k++) begin
      idx = phm_pkg::cfg_reg_e'(k);
      unique case (idx)
        phm_pkg::REG_DISPLAY_MODE: v = m;
        phm_pkg::REG_LEVEL_FALL:   v = fs;
        phm_pkg::REG_PEAK_ACCEL:   v = as;
        default:                   v = ds;
      endcase
      cfg_if.data <= '{reg_index: idx, wdata: v};
      @(posedge clk_i);
      while (!cfg_if.ready) @(posedge clk_i);
      unique case (idx)
        phm_pkg::REG_DISPLAY_MODE: cur_mode  = phm_pkg::mode_e'(v[1:0]);
        phm_pkg::REG_LEVEL_FALL:   fall_sel  = v;
        phm_pkg::REG_PEAK_ACCEL:   accel_sel = v;
        default:                   div_sel   = v[1:0];
      endcase
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_defaults();
    send_item(mk_item(7'd0,   8'hFF, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(mk_item(7'd0,   8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
    send_item(mk_item(7'd0,   8'h10, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(mk_item(7'd127, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0));
    send_item(mk_item(7'd127, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0));
    send_item(mk_item(7'd127, 8'h3C, 1'b1, 1'b0, 1'b1, 1'b1));
    send_item(mk_item(7'd0,   8'hFE, 1'b1, 1'b1, 1'b0, 1'b0));
    send_item(mk_item(7'd0,   8'hFF, 1'b1, 1'b0, 1'b0, 1'b0));
  endtask

  task automatic test_analyzer_paths();
    load_config(phm_pkg::MODE_ANALYZER, 3'd4, 3'd4, 3'd0);
    send_item(mk_item(7'd3, 8'd200, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(mk_item(7'd3, 8'd0,   1'b0, 1'b1, 1'b0, 1'b0));
    // rise that stays under the held peak
    send_item(mk_item(7'd3, 8'd199, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(mk_item(7'd3, 8'd0,   1'b0, 1'b1, 1'b1, 1'b0));
  endtask

  task automatic test_copy_modes();
    load_config(phm_pkg::MODE_VOICE, 3'd2, 3'd0, 3'd0);
    send_item(mk_item(7'd0,  8'h55, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(mk_item(7'd15, 8'hAA, 1'b1, 1'b1, 1'b0, 1'b0));
    send_item(mk_item(7'd16, 8'h12, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(mk_item(7'd15, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
    load_config(phm_pkg::MODE_SCOPE, 3'd2, 3'd0, 3'd0);
    send_item(mk_item(7'd9, 8'h77, 1'b1, 1'b0, 1'b0, 1'b1));
    send_item(mk_item(7'd9, 8'h80, 1'b1, 1'b1, 1'b0, 1'b0));
    load_config(phm_pkg::MODE_PLAIN, 3'd2, 3'd0, 3'd0);
    send_item(mk_item(7'd127, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(mk_item(7'd1,   8'h00, 1'b1, 1'b1, 1'b0, 1'b0));
  endtask

  task automatic test_redraw();
    load_config(phm_pkg::MODE_ANALYZER, 3'd2, 3'd0, 3'd2);
    repeat (5) send_item(mk_item(7'd2, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
  endtask

  task automatic test_backpressure();
    gap_on = 1'b0;
    hold_req <= 1'b1;
    repeat (50) send_item(rand_item());
    gap_on = 1'b1;
  endtask

  task automatic run_sweep(inout int sent);
    logic [6:0] start;
    int         len;
    logic       tick;
    start = (cur_mode == phm_pkg::MODE_VOICE && $urandom_range(0, 3) != 0) ?
            7'($urandom_range(0, 15)) : 7'($urandom_range(0, 127));
    len   = $urandom_range(4, 16);
    tick  = 1'($urandom_range(0, 1));
    for (int k = 0; k < len; k++) begin
      send_item(mk_item(7'(start + k), rand_level(), 1'($urandom_range(0, 7) != 0), tick,
                        1'(k == len - 1), 1'($urandom_range(0, 31) == 0)));
      sent++;
    end
  endtask

  task automatic run_decay(inout int sent);
    logic [6:0] b;
    int         len;
    b   = 7'($urandom_range(0, 127));
    len = $urandom_range(10, 90);
    send_item(mk_item(b, 8'($urandom_range(128, 255)), 1'b1, 1'b0, 1'b0, 1'b0));
    sent++;
    for (int k = 0; k < len; k++) begin
      send_item(mk_item(b, rand_level(), 1'($urandom_range(0, 7) == 0), 1'b1,
                        1'($urandom_range(0, 2) == 0), 1'b0));
      sent++;
    end
  endtask

  task automatic test_random_phases();
    int         sent;
    int         pick;
    logic [2:0] m;
    for (int p = 0; p < PHASES; p++) begin
      unique case (p)
        0: load_config(phm_pkg::MODE_ANALYZER, 3'd0, 3'd0, 3'd0);
        1: load_config(phm_pkg::MODE_ANALYZER, 3'd7, 3'd7, 3'd3);
        2: load_config(phm_pkg::MODE_VOICE,    3'd4, 3'd4, 3'd1);
        3: load_config(phm_pkg::MODE_SCOPE,    3'd5, 3'd6, 3'd2);
        4: load_config({1'b1, phm_pkg::MODE_PLAIN}, 3'd3, 3'd1, 3'd7);
        default: begin
          m = $urandom_range(0, 1) ? 3'd0 : 3'($urandom_range(1, 3));
          m[2] = 1'($urandom_range(0, 1));
          load_config(m, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                      3'($urandom_range(0, 7)));
        end
      endcase
      gap_on   = (p % 4 == 0) || (p % 4 == 1);
      stall_on <= (p % 4 == 0) || (p % 4 == 2);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          run_sweep(sent);
        end else if (pick < 7) begin
          run_decay(sent);
        end else begin
          send_item(rand_item());
          sent++;
        end
      end
    end
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    res_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        stall_left = HOLD_CYCLES;
        hold_req <= 1'b0;
      end else if (stall_left == 0 && stall_on && $urandom_range(0, 3) == 0) begin
        stall_left = ($urandom_range(0, 12) == 0) ? $urandom_range(12, 40)
                                                   : $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    phm_pkg::phm_out_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (reading_q.size() == 0) begin
        $error("unexpected result: level_out %h peak_out %h redraw %b",
               res_if.data.level_out, res_if.data.peak_out, res_if.data.redraw);
        err_cnt++;
      end else begin
        want = reading_q.pop_front();
        if (res_if.data.level_out !== want.level_out) begin
          $error("level_out mismatch: expected %h, actual %h", want.level_out,
                 res_if.data.level_out);
          err_cnt++;
        end
        if (res_if.data.peak_out !== want.peak_out) begin
          $error("peak_out mismatch: expected %h, actual %h", want.peak_out,
                 res_if.data.peak_out);
          err_cnt++;
        end
        if (res_if.data.redraw !== want.redraw) begin
          $error("redraw mismatch: expected %b, actual %b", want.redraw,
                 res_if.data.redraw);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_peak_hold_level_meter_top failed");
      $finish;
    end
  end

  initial begin
    item_if.valid <= 1'b0;
    item_if.data  <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.data   <= '{reg_index: phm_pkg::REG_DISPLAY_MODE, wdata: 3'd0};
    for (int i = 0; i < phm_pkg::BANDS; i++) begin
      lvl_mem[i] = '0;
      pk_mem[i]  = '0;
      spd_mem[i] = '0;
    end
    frame_cnt = '0;
    cur_mode  = phm_pkg::MODE_ANALYZER;
    fall_sel  = 3'd2;
    accel_sel = 3'd0;
    div_sel   = 2'd0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_defaults();
    test_analyzer_paths();
    test_copy_modes();
    test_redraw();
    test_backpressure();
    test_random_phases();

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0 && reading_q.size() == 0)
      $display("tb_peak_hold_level_meter_top passed");
    else
      $display("tb_peak_hold_level_meter_top failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/phm_pkg.sv
rtl/core/phm_if.sv
rtl/core/phm_ram.sv
rtl/core/phm_update.sv
rtl/core/peak_hold_level_meter_top.sv
dv/tb_peak_hold_level_meter_top.sv
